[rtl/mvbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvbf_pkg
// Shared types and constants of the vertical-byte monochrome frame buffer.
// ----------------------------------------------------------------------------
package mvbf_pkg;

    // Field widths
    localparam int COORD_W     = 10;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int PAGE_W      = 8;   // (y + row) >> 3 for y + row up to 2046
    localparam int SUM_COORD_W = COORD_W + 1;
    localparam int PROD_W      = PAGE_W + CFG_W;
    localparam int FULL_ADDR_W = 20;  // holds any page * stride + column + offset

    // Queue depths on either side of the engine
    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] STRIDE_RESET = 10'd128;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 10'd0;

    // Command codes on the input port
    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_FILL = 2'd2
    } cmd_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_STRIDE   = 1'b0,
        REG_START_OFFSET = 1'b1
    } cfg_reg_t;

    // Operation kind after classification in the front end
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_SET  = 2'd1,
        OP_GET  = 2'd2,
        OP_FILL = 2'd3
    } op_t;

    // One queued request for the engine
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic               color;
    } job_t;

    // One result
    typedef struct packed {
        logic pixel;
        logic err;
    } result_t;

endpackage

[rtl/mvbf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvbf_queue
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mvbf_queue #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_DEPTH);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_DEPTH)
        else $error("queue occupancy exceeds depth");
`endif

endmodule

[rtl/mvbf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvbf_front
// Accepts commands, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module mvbf_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mvbf_pkg::CMD_W-1:0]   command,
    input  logic [mvbf_pkg::COORD_W-1:0] pos_x,
    input  logic [mvbf_pkg::COORD_W-1:0] pos_y,
    input  logic [mvbf_pkg::COORD_W-1:0] rect_width,
    input  logic [mvbf_pkg::COORD_W-1:0] rect_height,
    input  logic                         color,
    input  logic                         clearing,
    output logic                         job_valid,
    input  logic                         job_pop,
    output mvbf_pkg::job_t               job
);

    mvbf_pkg::job_t                 job_in;
    logic                           q_full;
    logic                           q_empty;
    logic [$bits(mvbf_pkg::job_t)-1:0] q_rd_data;

    // Classify the command; an empty rectangle and an unused code do nothing
    always_comb
    begin
        job_in.x     = pos_x;
        job_in.y     = pos_y;
        job_in.w     = rect_width;
        job_in.h     = rect_height;
        job_in.color = color;
        case (mvbf_pkg::cmd_t'(command))
            mvbf_pkg::CMD_SET:  job_in.op = mvbf_pkg::OP_SET;
            mvbf_pkg::CMD_GET:  job_in.op = mvbf_pkg::OP_GET;
            mvbf_pkg::CMD_FILL:
            begin
                if (rect_width == '0 || rect_height == '0)
                begin
                    job_in.op = mvbf_pkg::OP_NONE;
                end
                else
                begin
                    job_in.op = mvbf_pkg::OP_FILL;
                end
            end
            default:            job_in.op = mvbf_pkg::OP_NONE;
        endcase
    end

    // Hold off requests while the frame memory is being cleared
    assign full      = q_full || clearing;
    assign job_valid = !q_empty;
    assign job       = mvbf_pkg::job_t'(q_rd_data);

    mvbf_queue #(
        .WIDTH ($bits(mvbf_pkg::job_t)),
        .DEPTH (mvbf_pkg::JOB_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (job_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

endmodule

[rtl/mvbf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvbf_back
// Frame memory and the engine that carries out set, get and fill requests
// by read-modify-write of one byte per pixel.
// ----------------------------------------------------------------------------
module mvbf_back #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mvbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mvbf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           job_valid,
    output logic                           job_pop,
    input  mvbf_pkg::job_t                 job,
    output logic                           clearing,
    output logic                           res_push,
    input  logic                           res_full,
    output mvbf_pkg::result_t              result
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int FAW = mvbf_pkg::FULL_ADDR_W;
    localparam int CW  = mvbf_pkg::COORD_W;
    localparam int SW  = mvbf_pkg::SUM_COORD_W;
    localparam logic [FAW-1:0] MEM_LIMIT = FAW'(MEM_BYTES);
    localparam logic [AW-1:0]  CLR_LAST  = AW'(MEM_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_READ,
        S_MOD,
        S_DONE
    } state_t;

    logic [7:0] frame_mem [MEM_BYTES];
    logic [7:0] rd_data_reg;

    state_t                             state_reg, state_next;
    mvbf_pkg::job_t                     job_reg, job_next;
    logic [CW-1:0]                      k_reg, k_next;
    logic [CW-1:0]                      r_reg, r_next;
    logic [mvbf_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [SW-1:0]                      col_reg, col_next;
    logic [2:0]                         sh_reg, sh_next;
    logic [FAW-1:0]                     addr_reg, addr_next;
    logic                               oob_reg, oob_next;
    logic                               err_reg, err_next;
    logic                               pix_reg, pix_next;
    logic [AW-1:0]                      clr_reg, clr_next;
    logic [mvbf_pkg::CFG_W-1:0]         stride_reg;
    logic [mvbf_pkg::CFG_W-1:0]         offset_reg;

    logic [SW-1:0]  row_sum;
    logic [FAW-1:0] addr_sum;
    logic [7:0]     bit_mask;
    logic [7:0]     merged;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           k_last;
    logic           r_last;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= mvbf_pkg::STRIDE_RESET;
            offset_reg <= mvbf_pkg::OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            case (mvbf_pkg::cfg_reg_t'(cfg_index))
                mvbf_pkg::REG_ROW_STRIDE:   stride_reg <= cfg_data;
                mvbf_pkg::REG_START_OFFSET: offset_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Address arithmetic and byte merge
    assign row_sum  = {1'b0, job_reg.y} + {1'b0, r_reg};
    assign addr_sum = FAW'(prod_reg) + FAW'(col_reg) + FAW'(offset_reg);
    assign bit_mask = 8'd1 << sh_reg;
    assign merged   = (rd_data_reg & ~bit_mask) | (job_reg.color ? bit_mask : 8'd0);
    assign k_last   = (k_reg == CW'(job_reg.w - 1'b1));
    assign r_last   = (r_reg == CW'(job_reg.h - 1'b1));

    // Handshakes and memory strobes
    assign clearing  = (state_reg == S_CLEAR);
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign res_push  = (state_reg == S_DONE) && !res_full;
    assign result    = '{pixel: pix_reg, err: err_reg};
    assign mem_re    = (state_reg == S_READ) && !oob_reg;
    assign mem_we    = clearing ||
                       ((state_reg == S_MOD) && !oob_reg && (job_reg.op != mvbf_pkg::OP_GET));
    assign mem_waddr = clearing ? clr_reg : addr_reg[AW-1:0];
    assign mem_wdata = clearing ? 8'd0 : merged;

    // Sequence one request pixel by pixel
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        prod_next  = prod_reg;
        col_next   = col_reg;
        sh_next    = sh_reg;
        addr_next  = addr_reg;
        oob_next   = oob_reg;
        err_next   = err_reg;
        pix_next   = pix_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    k_next   = '0;
                    r_next   = '0;
                    err_next = 1'b0;
                    pix_next = 1'b0;
                    state_next = (job.op == mvbf_pkg::OP_NONE) ? S_DONE : S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = row_sum[SW-1:3] * stride_reg;
                col_next   = {1'b0, job_reg.x} + {1'b0, k_reg};
                sh_next    = row_sum[2:0];
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                addr_next  = addr_sum;
                oob_next   = (addr_sum >= MEM_LIMIT);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (oob_reg)
                begin
                    err_next = 1'b1;
                end
                else if (job_reg.op == mvbf_pkg::OP_GET)
                begin
                    pix_next = rd_data_reg[sh_reg];
                end
                state_next = S_DONE;
                // Walk the rectangle column by column inside each row
                if (job_reg.op == mvbf_pkg::OP_FILL)
                begin
                    if (!k_last)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_MUL;
                    end
                    else if (!r_last)
                    begin
                        k_next     = '0;
                        r_next     = r_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            err_reg   <= 1'b0;
            pix_reg   <= 1'b0;
            oob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            err_reg   <= err_next;
            pix_reg   <= pix_next;
            oob_reg   <= oob_next;
        end
    end

    // Payload registers of the sequencer
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        prod_reg <= prod_next;
        col_reg  <= col_next;
        sh_reg   <= sh_next;
        addr_reg <= addr_next;
    end

    // Frame memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= frame_mem[addr_reg[AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !job_pop)
        else $error("request taken during clearing pass");

    a_oob_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && oob_reg) |-> !mem_we)
        else $error("out-of-range address written");

    a_fill_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && job_reg.op == mvbf_pkg::OP_FILL)
            |-> (k_reg < job_reg.w && r_reg < job_reg.h))
        else $error("fill walks outside the rectangle");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (state_reg == S_IDLE))
        else $error("engine not idle after delivering a result");
`endif

endmodule

[rtl/mono_vertical_byte_framebuffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_vertical_byte_framebuffer
// Monochrome vertical-byte frame store with pixel set, pixel get and
// rectangle fill; one result per request.
// ----------------------------------------------------------------------------
// After reset the frame memory is cleared one byte per cycle, with full held
// high; configuration writes are taken throughout.
// Each request then costs one read-modify-write of a byte per pixel through
// the frame memory with a stride multiply ahead of it: per pixel the engine
// forms and range-checks the address, reads the byte and, unless it is a get,
// writes it back; an empty fill or an unused command code only gives a result.
// Two requests queue ahead of the engine and two results behind it, so the
// input keeps taking requests while results wait to be popped, until both fill.
module mono_vertical_byte_framebuffer #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request side
    input  logic                           push,
    output logic                           full,
    input  logic [mvbf_pkg::CMD_W-1:0]     command,
    input  logic [mvbf_pkg::COORD_W-1:0]   pos_x,
    input  logic [mvbf_pkg::COORD_W-1:0]   pos_y,
    input  logic [mvbf_pkg::COORD_W-1:0]   rect_width,
    input  logic [mvbf_pkg::COORD_W-1:0]   rect_height,
    input  logic                           color,
    // Result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           pixel_value,
    output logic                           status,
    // Configuration
    input  logic                           cfg_write,
    input  logic [mvbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mvbf_pkg::CFG_W-1:0]     cfg_data
);

    mvbf_pkg::job_t    job;
    mvbf_pkg::result_t res;
    mvbf_pkg::result_t res_out;
    logic              job_valid;
    logic              job_pop;
    logic              clearing;
    logic              res_push;
    logic              res_full;

    mvbf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .color       (color),
        .clearing    (clearing),
        .job_valid   (job_valid),
        .job_pop     (job_pop),
        .job         (job)
    );

    mvbf_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .clearing  (clearing),
        .res_push  (res_push),
        .res_full  (res_full),
        .result    (res)
    );

    // Queue results until popped
    mvbf_queue #(
        .WIDTH ($bits(mvbf_pkg::result_t)),
        .DEPTH (mvbf_pkg::RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign pixel_value = res_out.pixel;
    assign status      = res_out.err;

endmodule
